// ===== hdl/msb_first_bit_packer_assert.svh =====
// Assertion macros for the MSB-first bit packer checker.
// No dependencies; included by the checker file.
`ifndef MSB_FIRST_BIT_PACKER_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_ASSERT_SVH

// Check a property while out of reset.
`define MFBP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MFBP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mfbp_pkg.sv =====
// Package for the MSB-first bit packer: request and result types, opcodes, constants.
// No dependencies.
`default_nettype none

package mfbp_pkg;

    localparam int MAX_FIELD_BITS_DEF = 32;
    localparam int BYTE_W             = 8;
    localparam int PEND_W             = BYTE_W - 1;
    localparam int QUEUE_DEPTH        = 2;
    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h00;

    typedef enum logic [0:0] {
        OP_APPEND = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] field_bits;
        logic [5:0]  field_length;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/mfbp_queue.sv =====
// Small register FIFO between the front and back parts of the bit packer.
// Uses mfbp_pkg.
`default_nettype none

module mfbp_queue
    import mfbp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  q_valid,
    output logic [WIDTH-1:0]      q_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mfbp_front.sv =====
// Front part of the bit packer: accepts requests, merges leftover bits, queues byte jobs.
// Uses mfbp_pkg.
`default_nettype none

module mfbp_front
    import mfbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF,
    parameter int ACC_W          = MAX_FIELD_BITS + PEND_W,
    parameter int TOT_W          = $clog2(ACC_W + 1)
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire in_item_t       s_item,
    output logic                job_push,
    output logic [ACC_W-1:0]    job_acc,
    output logic [TOT_W-1:0]    job_total,
    input  wire logic           job_full
);

    localparam int LEN_W = $clog2(MAX_FIELD_BITS + 1);
    localparam int CNT_W = $clog2(BYTE_W);

    logic [PEND_W-1:0]   pend_reg, pend_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]    len_sat;
    logic [ACC_W+31:0]   value_wide;
    logic [ACC_W-1:0]    value_ext;
    logic [ACC_W-1:0]    acc;
    logic [TOT_W-1:0]    total;
    logic [CNT_W-1:0]    rem;
    logic [PEND_W-1:0]   rem_mask;
    logic [BYTE_W-1:0]   flush_byte;
    logic                accept;
    logic                is_flush;

    assign s_ready  = !job_full;
    assign accept   = s_valid && s_ready;
    assign is_flush = (s_item.op == OP_FLUSH);

    always_comb begin
        len_sat    = (s_item.field_length > 6'(MAX_FIELD_BITS)) ? LEN_W'(MAX_FIELD_BITS)
                                                               : LEN_W'(s_item.field_length);
        value_wide = {{ACC_W{1'b0}}, s_item.field_bits};
        value_ext  = value_wide[ACC_W-1:0] & ((ACC_W'(1) << len_sat) - ACC_W'(1));
        acc        = (ACC_W'(pend_reg) << len_sat) | value_ext;
        total      = TOT_W'(cnt_reg) + TOT_W'(len_sat);
        rem        = total[CNT_W-1:0];
        rem_mask   = (PEND_W'(1) << rem) - PEND_W'(1);
        flush_byte = (BYTE_W'(pend_reg) << ((CNT_W+1)'(BYTE_W) - (CNT_W+1)'(cnt_reg)))
                     | PAD_BYTE;
    end

    always_comb begin
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        job_push  = 1'b0;
        job_acc   = acc;
        job_total = total;
        if (is_flush) begin
            job_acc   = ACC_W'(flush_byte);
            job_total = TOT_W'(BYTE_W);
            if (accept) begin
                job_push  = (cnt_reg != '0);
                pend_next = '0;
                cnt_next  = '0;
            end
        end else if (accept) begin
            job_push  = (total >= TOT_W'(BYTE_W));
            pend_next = acc[PEND_W-1:0] & rem_mask;
            cnt_next  = rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mfbp_back.sv =====
// Back part of the bit packer: walks each queued job and emits one byte per cycle while the output is not stalled.
// Uses mfbp_pkg.
`default_nettype none

module mfbp_back
    import mfbp_pkg::*;
#(
    parameter int ACC_W = MAX_FIELD_BITS_DEF + PEND_W,
    parameter int TOT_W = $clog2(ACC_W + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire logic [ACC_W-1:0] q_acc,
    input  wire logic [TOT_W-1:0] q_total,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output out_item_t          m_item
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [TOT_W-1:0] sh_reg, sh_next;
    logic             busy_reg, busy_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;
    logic             out_free, emit, last_b, fin;
    logic [ACC_W-1:0] shifted;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = busy_reg && out_free;
    assign last_b   = (sh_reg < TOT_W'(BYTE_W));
    assign fin      = emit && last_b;
    assign q_pop    = q_valid && (!busy_reg || fin);
    assign shifted  = acc_reg >> sh_reg;

    always_comb begin
        acc_next     = acc_reg;
        sh_next      = sh_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        if (emit) begin
            m_valid_next         = 1'b1;
            m_item_next.out_byte = shifted[BYTE_W-1:0];
            m_item_next.last     = last_b;
            sh_next              = sh_reg - TOT_W'(BYTE_W);
            if (last_b) begin
                busy_next = 1'b0;
            end
        end
        if (q_pop) begin
            acc_next  = q_acc;
            sh_next   = q_total - TOT_W'(BYTE_W);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        sh_reg     <= sh_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// ===== hdl/msb_first_bit_packer.sv =====
// Top level of the MSB-first bit packer: front, job queue and back parts.
// Uses mfbp_pkg, mfbp_front, mfbp_queue, mfbp_back.
//
//  channel | ports                     | carries
//  s_      | s_valid s_ready s_item    | op, field_bits, field_length
//  m_      | m_valid m_ready m_item    | out_byte, last
//
// The front takes one request per cycle while the two-entry job queue has room.
// The back emits one byte per cycle while m_ready does not stall the output register.
// A request completes up to (7 + MAX_FIELD_BITS) / 8 bytes, four with the default width.
// The first byte of a request passes through the job queue, the back part's job registers
// and the output register before it shows on m_valid; requests that complete no byte push
// no job. Reset is synchronous and clears leftover bits, queue and output.
// An output stall fills the output register, then the queue, then drops s_ready.
`default_nettype none

module msb_first_bit_packer
    import mfbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_item
);

    localparam int ACC_W = MAX_FIELD_BITS + PEND_W;
    localparam int TOT_W = $clog2(ACC_W + 1);
    localparam int JOB_W = ACC_W + TOT_W;

    logic             job_push, job_full, q_valid, q_pop;
    logic [ACC_W-1:0] job_acc;
    logic [TOT_W-1:0] job_total;
    logic [JOB_W-1:0] q_data;

    mfbp_front #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS),
        .ACC_W(ACC_W),
        .TOT_W(TOT_W)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .job_push(job_push),
        .job_acc(job_acc),
        .job_total(job_total),
        .job_full(job_full)
    );

    mfbp_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(job_push),
        .push_data({job_total, job_acc}),
        .full(job_full),
        .pop(q_pop),
        .q_valid(q_valid),
        .q_data(q_data)
    );

    mfbp_back #(
        .ACC_W(ACC_W),
        .TOT_W(TOT_W)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_acc(q_data[ACC_W-1:0]),
        .q_total(q_data[JOB_W-1:ACC_W]),
        .q_pop(q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item)
    );

endmodule

`default_nettype wire

// ===== hdl/mfbp_checker.sv =====
// Port-level checker for the MSB-first bit packer, bound to the top level.
// Uses mfbp_pkg and msb_first_bit_packer_assert.svh.
`default_nettype none

`include "msb_first_bit_packer_assert.svh"

module mfbp_checker
    import mfbp_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_item,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item
);

    `MFBP_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "m_valid after reset")
    `MFBP_ASSERT_ALWAYS(a_reset_opens_in, aclk, !aresetn |=> s_ready, "s_ready low after reset")
    `MFBP_ASSERT(a_out_hold, aclk, aresetn,
                 m_valid && !m_ready |=> m_valid && $stable(m_item), "stalled result changed")
    `MFBP_ASSERT(a_in_hold, aclk, aresetn,
                 s_valid && !s_ready |=> s_valid && $stable(s_item), "stalled request changed")

endmodule

bind msb_first_bit_packer mfbp_checker u_mfbp_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_item(s_item),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_item(m_item)
);

`default_nettype wire

// ===== tb/msb_first_bit_packer_checker.sv =====
// Checker for the MSB-first bit packer: watches both channels, predicts the packed bytes.
// Depends on mfbp_pkg for the request and result types and the opcodes.
module msb_first_bit_packer_checker
    import mfbp_pkg::*;
#(
    parameter int MAX_LEN = MAX_FIELD_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_item,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_item,
    output int             mismatch_count,
    output int             bytes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] left_bits;
    logic [2:0] left_count;
    out_item_t  expected_bytes[$];

    task automatic pack_request(input in_item_t req);
        logic [63:0] acc;
        logic [63:0] mask;
        out_item_t   b;
        int          len;
        int          total;
        int          nbytes;
        int          sh;
        if (req.op == OP_FLUSH) begin
            if (left_count != 0) begin
                b.out_byte = 8'(left_bits << (BYTE_W - int'(left_count))) | PAD_BYTE;
                b.last     = 1'b1;
                expected_bytes.push_back(b);
                left_bits  = '0;
                left_count = '0;
            end
            return;
        end
        len = int'(req.field_length);
        if (len > MAX_LEN)
            len = MAX_LEN;
        if (len == 0)
            return;
        mask   = (64'd1 << len) - 64'd1;
        acc    = (64'(left_bits) << len) | (64'(req.field_bits) & mask);
        total  = int'(left_count) + len;
        nbytes = total / BYTE_W;
        for (int i = 0; i < nbytes; i++) begin
            sh         = total - BYTE_W * (i + 1);
            b.out_byte = 8'(acc >> sh);
            b.last     = (i == nbytes - 1);
            expected_bytes.push_back(b);
        end
        left_count = 3'(total % BYTE_W);
        left_bits  = 8'(acc & ((64'd1 << (total % BYTE_W)) - 64'd1));
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            left_bits  = '0;
            left_count = '0;
            expected_bytes.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                             $time, m_item.out_byte, m_item.last);
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_item.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want.out_byte, m_item.out_byte);
                        mismatch_count++;
                    end
                    if (m_item.last !== want.last) begin
                        $display("%0t: last mismatch, expected %0b, actual %0b",
                                 $time, want.last, m_item.last);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                pack_request(s_item);
        end
        bytes_owed = expected_bytes.size();
    end

endmodule

// ===== tb/msb_first_bit_packer_tb.sv =====
// Testbench top for the MSB-first bit packer: clock, reset, request and result traffic.
// Depends on mfbp_pkg, msb_first_bit_packer and msb_first_bit_packer_checker.
module msb_first_bit_packer_tb;
    import mfbp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQS = 470;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;
    int        mismatch_count;
    int        bytes_owed;
    int        req_index;

    msb_first_bit_packer #(.MAX_FIELD_BITS(MAX_FIELD_BITS_DEF)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    msb_first_bit_packer_checker #(.MAX_LEN(MAX_FIELD_BITS_DEF)) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item),
        .mismatch_count (mismatch_count),
        .bytes_owed     (bytes_owed)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic in_item_t mk_req(op_t op, logic [31:0] bits, logic [5:0] len);
        in_item_t r;
        r.op           = op;
        r.field_bits   = bits;
        r.field_length = len;
        return r;
    endfunction

    task automatic offer_request(input in_item_t req);
        int gap;
        gap = (((req_index / 40) % 3) == 1) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        req_index++;
    endtask

    // receiver: random stalls, stall-free stretches, two long hold-offs
    initial begin
        int stall;
        int taken;
        taken   = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (taken == 80 || taken == 300)
                stall = 200;
            else if (((taken / 50) % 3) == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
            taken++;
        end
    end

    initial begin
        int r;
        int guard;
        logic [5:0] len;
        s_valid   = 1'b0;
        s_item    = '0;
        aresetn   = 1'b0;
        req_index = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        offer_request(mk_req(OP_APPEND, 32'hFFFF_FFFF, 6'd0));
        offer_request(mk_req(OP_FLUSH,  32'hFFFF_FFFF, 6'd63));
        offer_request(mk_req(OP_APPEND, 32'hFFFF_FFFF, 6'd32));
        offer_request(mk_req(OP_APPEND, 32'h0000_0001, 6'd1));
        offer_request(mk_req(OP_APPEND, 32'h0000_0000, 6'd32));
        offer_request(mk_req(OP_FLUSH,  32'h0000_0000, 6'd0));
        offer_request(mk_req(OP_APPEND, 32'hFFFF_FFFF, 6'd3));
        offer_request(mk_req(OP_APPEND, 32'hFFFF_FFF5, 6'd4));
        offer_request(mk_req(OP_APPEND, 32'hFFFF_FFFE, 6'd1));
        offer_request(mk_req(OP_APPEND, 32'hFFFF_FFFF, 6'd33));
        offer_request(mk_req(OP_APPEND, 32'hA5A5_A5A5, 6'd63));
        offer_request(mk_req(OP_APPEND, 32'h0000_0001, 6'd2));
        offer_request(mk_req(OP_FLUSH,  32'h1234_5678, 6'd17));
        offer_request(mk_req(OP_APPEND, 32'h0000_007F, 6'd7));
        offer_request(mk_req(OP_APPEND, 32'h8000_0001, 6'd32));
        offer_request(mk_req(OP_FLUSH,  32'h0000_0000, 6'd32));
        offer_request(mk_req(OP_APPEND, 32'hFFFF_FF00, 6'd8));
        offer_request(mk_req(OP_APPEND, 32'h0000_00FF, 6'd8));
        offer_request(mk_req(OP_APPEND, 32'hFFFF_FFFF, 6'd5));
        offer_request(mk_req(OP_APPEND, 32'h0000_0000, 6'd40));
        offer_request(mk_req(OP_FLUSH,  32'h0000_0000, 6'd0));
        offer_request(mk_req(OP_FLUSH,  32'h0000_0000, 6'd0));

        for (int i = 0; i < RANDOM_REQS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                len = 6'($urandom);
            else if (r < 25)
                len = 6'd0;
            else if (r < 35)
                len = 6'($urandom_range(33, 63));
            else if (r < 50)
                len = 6'($urandom_range(1, 8));
            else
                len = 6'($urandom_range(1, 32));
            if (r < 15)
                offer_request(mk_req(OP_FLUSH, $urandom, len));
            else
                offer_request(mk_req(OP_APPEND, $urandom, len));
        end
        s_valid <= 1'b0;

        guard = 0;
        while (bytes_owed != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && bytes_owed == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mfbp_pkg.sv
hdl/mfbp_queue.sv
hdl/mfbp_front.sv
hdl/mfbp_back.sv
hdl/msb_first_bit_packer.sv
hdl/mfbp_checker.sv
tb/msb_first_bit_packer_checker.sv
tb/msb_first_bit_packer_tb.sv
